FILE: hdl/ffba_pkg.sv
package ffba_pkg;

	localparam int HEAP_BYTES_DEF   = 65536;
	localparam int HEADER_BYTES_DEF = 12;
	localparam int MAX_BLOCKS_DEF   = 8192;

	localparam logic       OP_ALLOC   = 1'b0;
	localparam logic       OP_RELEASE = 1'b1;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_NOFIT   = 2'd1;
	localparam logic [1:0] ST_NULL    = 2'd2;
	localparam logic [1:0] ST_UNKNOWN = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD,
		S_CHK,
		S_SHIFT_UP,
		S_SPLIT,
		S_MARK,
		S_NEXT_RD,
		S_NEXT_CHK,
		S_PREV_RD,
		S_PREV_CHK,
		S_SHIFT_DN,
		S_OUT
	} state_t;

	// one table entry: header start, payload size, free mark
	typedef struct packed {
		logic [15:0] start;
		logic [16:0] payload;
		logic        free;
	} entry_t;

endpackage

FILE: hdl/ffba_table.sv
// block table memory: one write port, one registered read port
module ffba_table #(
	parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF,
	localparam int AW = $clog2(MAX_BLOCKS)
) (
	input  logic                    clk,
	input  logic                    we,
	input  logic [AW-1:0]           waddr,
	input  ffba_pkg::entry_t        wdata,
	input  logic [AW-1:0]           raddr,
	output ffba_pkg::entry_t        rdata
);

	ffba_pkg::entry_t mem [MAX_BLOCKS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/first_fit_block_allocator.sv
// First-fit heap allocator over a table of blocks kept in physical order.
// Input channel (valid/ready): operation, request_size, release_offset.
// Output channel (valid/ready): granted_offset, status; one word per item.
// Allocate scans the table from entry 0 for the first free block large
// enough; a split inserts an entry by shifting the tail up, each moved
// entry read and then written. Release searches for the matching offset,
// then merges with a free next and previous block, each merge shifting the
// tail down. A scan reads one entry at a time (one table read port,
// registered read); a null release skips the scan. One item at a
// time: in_ready is low from acceptance until the result word is taken.
// Reset: the table holds one free block spanning the heap (entry 0 is
// written while init_q is low after reset, during which no item is taken);
// entries beyond the count are never used.
// A stalled receiver holds the result in the output register; no new item
// is accepted until it leaves.
module first_fit_block_allocator #(
	parameter int HEAP_BYTES   = ffba_pkg::HEAP_BYTES_DEF,
	parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF,
	parameter int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF,
	localparam int AW = $clog2(MAX_BLOCKS),
	localparam int CW = AW + 1
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [16:0] request_size,
	input  logic [15:0] release_offset,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] granted_offset,
	output logic [1:0]  status
);

	localparam logic [16:0] HDR17  = 17'(HEADER_BYTES);
	localparam logic [15:0] HDR16  = 16'(HEADER_BYTES);
	localparam logic [16:0] SPLITL = 17'(HEADER_BYTES + 8);
	localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);
	// requests above this would wrap when rounded; the cap still fits no block
	localparam logic [16:0] SIZE_CAP = 17'h1FFF8;

	ffba_pkg::state_t state_q, state_d;

	logic          init_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;      // current entry
	logic [CW-1:0] ptr_q;      // shift pointer
	logic          op_q;
	logic [16:0]   size_q;
	logic [15:0]   off_q;
	ffba_pkg::entry_t cur_q;   // entry at idx_q
	ffba_pkg::entry_t nb_q;    // entry as read (split source or neighbor)
	logic [15:0]   res_off_q;
	logic [1:0]    res_st_q;

	// memory ports
	logic                 we;
	logic [AW-1:0]        waddr, raddr;
	ffba_pkg::entry_t     wdata, rdata;

	ffba_table #(.MAX_BLOCKS(MAX_BLOCKS)) u_table (
		.clk, .we, .waddr, .wdata, .raddr, .rdata
	);

	// shared compare/add unit
	logic [16:0] rest;
	logic        fits;
	logic        hit;
	logic [16:0] merged;
	ffba_pkg::entry_t chk_entry;
	assign fits   = rdata.free && (rdata.payload >= size_q);
	assign rest   = rdata.payload - size_q;
	assign hit    = (16'(rdata.start + HDR16) == off_q);
	// previous entry (rdata) absorbs the current one
	assign merged = 17'(cur_q.payload + rdata.payload + HDR17);

	// entry as it is kept after the check step
	always_comb begin
		chk_entry = rdata;
		if (op_q == ffba_pkg::OP_ALLOC) begin
			chk_entry.free = 1'b0;
			if (rest > SPLITL && count_q < MAXC) chk_entry.payload = size_q;
		end else begin
			chk_entry.free = 1'b1;
		end
	end

	assign in_ready  = (state_q == ffba_pkg::S_IDLE) && init_q;
	assign out_valid = (state_q == ffba_pkg::S_OUT);
	assign granted_offset = res_off_q;
	assign status         = res_st_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ffba_pkg::S_IDLE: begin
				if (in_valid && in_ready) begin
					if (operation == ffba_pkg::OP_RELEASE && release_offset == '0)
						state_d = ffba_pkg::S_OUT;
					else
						state_d = ffba_pkg::S_RD;
				end
			end
			ffba_pkg::S_RD: begin
				state_d = (idx_q == count_q) ? ffba_pkg::S_OUT : ffba_pkg::S_CHK;
			end
			ffba_pkg::S_CHK: begin
				if (op_q == ffba_pkg::OP_ALLOC) begin
					if (!fits)
						state_d = ffba_pkg::S_RD;
					else if (rest > SPLITL && count_q < MAXC)
						state_d = ffba_pkg::S_SHIFT_UP;
					else
						state_d = ffba_pkg::S_MARK;
				end else begin
					state_d = hit ? ffba_pkg::S_NEXT_RD : ffba_pkg::S_RD;
				end
			end
			ffba_pkg::S_SHIFT_UP: begin
				// ptr walks down; each step reads ptr-1 then writes ptr
				if (ptr_q == idx_q + 1'b1) state_d = ffba_pkg::S_SPLIT;
			end
			ffba_pkg::S_SPLIT:    state_d = ffba_pkg::S_MARK;
			ffba_pkg::S_MARK:     state_d = ffba_pkg::S_OUT;
			ffba_pkg::S_NEXT_RD: begin
				state_d = (idx_q + 1'b1 < count_q) ? ffba_pkg::S_NEXT_CHK
				                                   : ffba_pkg::S_PREV_RD;
			end
			ffba_pkg::S_NEXT_CHK: begin
				state_d = rdata.free ? ffba_pkg::S_SHIFT_DN : ffba_pkg::S_PREV_RD;
			end
			ffba_pkg::S_PREV_RD: begin
				state_d = (idx_q != '0) ? ffba_pkg::S_PREV_CHK : ffba_pkg::S_OUT;
			end
			ffba_pkg::S_PREV_CHK: begin
				state_d = rdata.free ? ffba_pkg::S_SHIFT_DN : ffba_pkg::S_OUT;
			end
			ffba_pkg::S_SHIFT_DN: begin
				if (ptr_q >= count_q) state_d = ffba_pkg::S_PREV_RD;
			end
			ffba_pkg::S_OUT: begin
				if (out_ready) state_d = ffba_pkg::S_IDLE;
			end
			default: state_d = ffba_pkg::S_IDLE;
		endcase
	end

	// shift phase: 0 = read issued, 1 = data back, write
	logic ph_q;

	// memory port control
	always_comb begin
		we    = 1'b0;
		waddr = idx_q[AW-1:0];
		wdata = cur_q;
		raddr = idx_q[AW-1:0];
		case (state_q)
			ffba_pkg::S_IDLE: begin
				if (!init_q) begin
					we    = 1'b1;
					waddr = '0;
					wdata = '{start: '0, payload: 17'(HEAP_BYTES - HEADER_BYTES),
					          free: 1'b1};
				end
			end
			ffba_pkg::S_SHIFT_UP: begin
				raddr = AW'(ptr_q - 1'b1);
				we    = ph_q;
				waddr = AW'(ptr_q);
				wdata = rdata;
			end
			ffba_pkg::S_SPLIT: begin
				we    = 1'b1;
				waddr = AW'(idx_q + 1'b1);
				wdata = '{start: 16'(cur_q.start + HDR16 + 16'(size_q)),
				          payload: 17'(nb_q.payload - size_q - HDR17), free: 1'b1};
			end
			ffba_pkg::S_MARK: begin
				we    = 1'b1;
				wdata = cur_q;
			end
			ffba_pkg::S_NEXT_RD: raddr = AW'(idx_q + 1'b1);
			ffba_pkg::S_PREV_RD: begin
				raddr = AW'(idx_q - 1'b1);
				we    = 1'b1;
				wdata = cur_q;
			end
			ffba_pkg::S_SHIFT_DN: begin
				raddr = AW'(ptr_q);
				we    = ph_q;
				waddr = AW'(ptr_q - 1'b1);
				wdata = rdata;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffba_pkg::S_IDLE;
			init_q  <= 1'b0;
			count_q <= CW'(1);
			ph_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			init_q  <= 1'b1;
			case (state_q)
				ffba_pkg::S_SHIFT_UP: begin
					ph_q <= ~ph_q;
					if (state_d == ffba_pkg::S_SPLIT) count_q <= count_q + 1'b1;
				end
				ffba_pkg::S_SHIFT_DN: begin
					ph_q <= ~ph_q;
					if (state_d != ffba_pkg::S_SHIFT_DN) count_q <= count_q - 1'b1;
				end
				default: ph_q <= 1'b0;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ffba_pkg::S_IDLE: begin
				op_q   <= operation;
				size_q <= (request_size > SIZE_CAP) ? SIZE_CAP
				                                    : ((request_size + 17'd7) & ~17'd7);
				off_q  <= release_offset;
				idx_q  <= '0;
				res_off_q <= '0;
				res_st_q  <= (operation == ffba_pkg::OP_RELEASE) ? ffba_pkg::ST_NULL
				                                                 : ffba_pkg::ST_DONE;
			end
			ffba_pkg::S_RD: begin
				if (idx_q == count_q) begin
					res_off_q <= '0;
					res_st_q  <= (op_q == ffba_pkg::OP_ALLOC) ? ffba_pkg::ST_NOFIT
					                                          : ffba_pkg::ST_UNKNOWN;
				end
			end
			ffba_pkg::S_CHK: begin
				cur_q <= chk_entry;
				nb_q  <= rdata;
				ptr_q <= count_q;
				if (op_q == ffba_pkg::OP_ALLOC) begin
					if (fits) begin
						res_off_q <= 16'(rdata.start + HDR16);
						res_st_q  <= ffba_pkg::ST_DONE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end else begin
					if (hit) begin
						res_st_q   <= ffba_pkg::ST_DONE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
			end
			ffba_pkg::S_SHIFT_UP: begin
				if (ph_q) ptr_q <= ptr_q - 1'b1;
			end
			ffba_pkg::S_NEXT_CHK: begin
				nb_q <= rdata;
				if (rdata.free) begin
					cur_q.payload <= 17'(cur_q.payload + rdata.payload + HDR17);
					ptr_q <= idx_q + 2'd2;
				end
			end
			ffba_pkg::S_PREV_CHK: begin
				nb_q <= rdata;
				if (rdata.free) begin
					// previous entry absorbs current; it becomes the current entry
					cur_q <= '{start: rdata.start, payload: merged, free: 1'b1};
					idx_q <= idx_q - 1'b1;
					ptr_q <= idx_q + 1'b1;
				end
			end
			ffba_pkg::S_SHIFT_DN: begin
				if (ph_q) ptr_q <= ptr_q + 1'b1;
			end
			default: ;
		endcase
	end

	property p_ready_only_idle;
		@(posedge clk) disable iff (!arst_n)
			in_ready |-> !out_valid;
	endproperty
	a_ready_only_idle: assert property (p_ready_only_idle)
		else $error("ready while result pending");

	property p_count_range;
		@(posedge clk) disable iff (!arst_n)
			(count_q != '0) && (count_q <= MAXC);
	endproperty
	a_count_range: assert property (p_count_range)
		else $error("block count out of range");

	property p_nofit_zero;
		@(posedge clk) disable iff (!arst_n)
			(out_valid && status != ffba_pkg::ST_DONE) |-> (granted_offset == '0);
	endproperty
	a_nofit_zero: assert property (p_nofit_zero)
		else $error("failed item carries an offset");

endmodule

FILE: tb/first_fit_block_allocator_tb.sv
// Testbench for first_fit_block_allocator.
// A directed table runs first, then random allocate/release traffic. Every
// accepted word is fed to a local copy of the block table that predicts
// the result word; result words are checked in order against that queue.
module first_fit_block_allocator_tb;

	localparam int HEAP     = ffba_pkg::HEAP_BYTES_DEF;
	localparam int HDR      = ffba_pkg::HEADER_BYTES_DEF;
	localparam int NBLK     = ffba_pkg::MAX_BLOCKS_DEF;
	localparam int N_RANDOM = 1630;
	localparam int WDOG_MAX = 8 * NBLK + 1000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        operation;
	logic [16:0] request_size;
	logic [15:0] release_offset;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] granted_offset;
	logic [1:0]  status;

	first_fit_block_allocator DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .request_size(request_size),
		.release_offset(release_offset),
		.out_valid(out_valid), .out_ready(out_ready),
		.granted_offset(granted_offset), .status(status)
	);

	typedef struct {
		logic [15:0] offset;
		logic [1:0]  st;
	} grant_t;

	// directed row: pinned=1 means the expected word is typed in here
	typedef struct {
		logic        op;
		logic [16:0] size;
		logic [15:0] off;
		bit          pinned;
		logic [15:0] exp_off;
		logic [1:0]  exp_st;
	} row_t;

	// shadow of the block table
	logic [15:0] blk_start [NBLK];
	int          blk_payload [NBLK];
	bit          blk_free [NBLK];
	int          blk_count;

	grant_t pending_grants[$];
	int     errors;
	int     wdog;
	bit     quiet;      // no random idling on either side
	bit     hold_req;   // ask receiver for a long hold-off
	bit     pin_en;
	grant_t pin_word;

	function automatic void tbl_insert(int pos);
		for (int k = blk_count; k > pos; k--) begin
			blk_start[k]   = blk_start[k-1];
			blk_payload[k] = blk_payload[k-1];
			blk_free[k]    = blk_free[k-1];
		end
		blk_count++;
	endfunction

	function automatic void tbl_remove(int pos);
		for (int k = pos; k < blk_count - 1; k++) begin
			blk_start[k]   = blk_start[k+1];
			blk_payload[k] = blk_payload[k+1];
			blk_free[k]    = blk_free[k+1];
		end
		blk_count--;
	endfunction

	function automatic grant_t heap_alloc(logic [16:0] req);
		grant_t g;
		int     need;
		int     rest;
		need = (int'(req) + 7) & ~7;
		g.offset = '0;
		g.st     = ffba_pkg::ST_NOFIT;
		for (int i = 0; i < blk_count; i++) begin
			if (blk_free[i] && blk_payload[i] >= need) begin
				rest = blk_payload[i] - need;
				if (rest > HDR + 8 && blk_count < NBLK) begin
					tbl_insert(i + 1);
					blk_start[i+1]   = 16'(int'(blk_start[i]) + HDR + need);
					blk_payload[i+1] = rest - HDR;
					blk_free[i+1]    = 1'b1;
					blk_payload[i]   = need;
				end
				blk_free[i] = 1'b0;
				g.offset = 16'(int'(blk_start[i]) + HDR);
				g.st     = ffba_pkg::ST_DONE;
				return g;
			end
		end
		return g;
	endfunction

	function automatic grant_t heap_release(logic [15:0] off);
		grant_t g;
		int     i;
		g.offset = '0;
		if (off == 16'd0) begin
			g.st = ffba_pkg::ST_NULL;
			return g;
		end
		for (i = 0; i < blk_count; i++)
			if (int'(blk_start[i]) + HDR == int'(off))
				break;
		if (i == blk_count) begin
			g.st = ffba_pkg::ST_UNKNOWN;
			return g;
		end
		blk_free[i] = 1'b1;
		if (i + 1 < blk_count && blk_free[i+1]) begin
			blk_payload[i] += blk_payload[i+1] + HDR;
			tbl_remove(i + 1);
		end
		if (i > 0 && blk_free[i-1]) begin
			blk_payload[i-1] += blk_payload[i] + HDR;
			tbl_remove(i);
		end
		g.st = ffba_pkg::ST_DONE;
		return g;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// input side: predict on every accepted word
	always @(posedge clk) begin
		grant_t g;
		if (arst_n && in_valid && in_ready) begin
			g = (operation == ffba_pkg::OP_ALLOC) ? heap_alloc(request_size)
			                                      : heap_release(release_offset);
			if (pin_en)
				g = pin_word;
			pending_grants.push_back(g);
		end
	end

	// output side: compare each result word with the oldest prediction
	always @(posedge clk) begin
		grant_t g;
		if (arst_n && out_valid && out_ready) begin
			if (pending_grants.size() == 0) begin
				$display("%0t: unexpected word offset=%0d status=%0d",
					$time, granted_offset, status);
				errors++;
			end else begin
				g = pending_grants.pop_front();
				if (granted_offset !== g.offset) begin
					$display("%0t: granted_offset expected %0d actual %0d",
						$time, g.offset, granted_offset);
					errors++;
				end
				if (status !== g.st) begin
					$display("%0t: status expected %0d actual %0d",
						$time, g.st, status);
					errors++;
				end
			end
		end
	end

	// watchdog: cycles with no accepted word on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			wdog <= 0;
		else
			wdog <= wdog + 1;
		if (wdog > WDOG_MAX) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// receiver: random back-pressure, plus one long hold-off on request
	initial begin
		int hold;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready = 1'b0;
				for (hold = 0; hold < 400; hold++)
					@(negedge clk);
				hold_req = 1'b0;
			end
			out_ready = quiet || ($urandom_range(99) >= 22);
		end
	end

	// starts and ends at a falling edge; valid drops after the word is taken
	task automatic send(logic op, logic [16:0] size, logic [15:0] off);
		while (!quiet && $urandom_range(99) < 22) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		operation      = op;
		request_size   = size;
		release_offset = off;
		in_valid       = 1'b1;
		do @(posedge clk); while (!(in_valid && in_ready));
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	row_t rows[$];

	initial begin
		row_t r;
		logic        op;
		logic [16:0] size;
		logic [15:0] off;
		int          pick;

		errors = 0;
		wdog = 0;
		quiet = 1'b0;
		hold_req = 1'b0;
		pin_en = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = ffba_pkg::OP_ALLOC;
		request_size = '0;
		release_offset = '0;
		blk_start[0] = '0;
		blk_payload[0] = HEAP - HDR;
		blk_free[0] = 1'b1;
		blk_count = 1;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		rows = '{
			'{ffba_pkg::OP_ALLOC,   17'd0,     16'd0,    1, 16'd12, ffba_pkg::ST_DONE},
			'{ffba_pkg::OP_ALLOC,   17'd65536, 16'd0,    1, 16'd0,  ffba_pkg::ST_NOFIT},
			'{ffba_pkg::OP_ALLOC,   17'h1ffff, 16'd0,    1, 16'd0,  ffba_pkg::ST_NOFIT},
			'{ffba_pkg::OP_RELEASE, 17'd0,     16'd0,    1, 16'd0,  ffba_pkg::ST_NULL},
			'{ffba_pkg::OP_RELEASE, 17'h1ffff, 16'd5,    1, 16'd0,  ffba_pkg::ST_UNKNOWN},
			'{ffba_pkg::OP_RELEASE, 17'd0,     16'hffff, 1, 16'd0,  ffba_pkg::ST_UNKNOWN},
			'{ffba_pkg::OP_ALLOC,   17'd1,     16'hffff, 1, 16'd24, ffba_pkg::ST_DONE},
			'{ffba_pkg::OP_ALLOC,   17'd8,     16'd0,    0, 16'd0,  ffba_pkg::ST_DONE},
			'{ffba_pkg::OP_ALLOC,   17'd100,   16'd0,    0, 16'd0,  ffba_pkg::ST_DONE},
			'{ffba_pkg::OP_RELEASE, 17'd0,     16'd24,   0, 16'd0,  ffba_pkg::ST_DONE},
			'{ffba_pkg::OP_RELEASE, 17'd0,     16'd24,   0, 16'd0,  ffba_pkg::ST_DONE},
			'{ffba_pkg::OP_RELEASE, 17'd0,     16'd12,   0, 16'd0,  ffba_pkg::ST_DONE},
			'{ffba_pkg::OP_ALLOC,   17'd16,    16'd0,    0, 16'd0,  ffba_pkg::ST_DONE},
			'{ffba_pkg::OP_ALLOC,   17'd30000, 16'd0,    0, 16'd0,  ffba_pkg::ST_DONE},
			'{ffba_pkg::OP_ALLOC,   17'd40000, 16'd0,    0, 16'd0,  ffba_pkg::ST_DONE},
			'{ffba_pkg::OP_RELEASE, 17'd0,     16'd44,   0, 16'd0,  ffba_pkg::ST_DONE},
			'{ffba_pkg::OP_ALLOC,   17'd30000, 16'd0,    0, 16'd0,  ffba_pkg::ST_DONE},
			'{ffba_pkg::OP_RELEASE, 17'd0,     16'd0,    0, 16'd0,  ffba_pkg::ST_DONE},
			'{ffba_pkg::OP_ALLOC,   17'd65524, 16'd0,    0, 16'd0,  ffba_pkg::ST_DONE}
		};
		foreach (rows[i]) begin
			r = rows[i];
			pin_en = r.pinned;
			pin_word.offset = r.exp_off;
			pin_word.st = r.exp_st;
			send(r.op, r.size, r.off);
		end
		@(negedge clk);
		pin_en = 1'b0;

		for (int n = 0; n < N_RANDOM; n++) begin
			quiet = (n >= 300 && n < 500);
			if (n == 700)
				hold_req = 1'b1;      // receiver stalls, sender keeps offering
			if (n == 1000) begin
				@(negedge clk);
				in_valid = 1'b0;
				wait (pending_grants.size() == 0 && !out_valid);
				@(negedge clk);
			end
			op = ($urandom_range(99) < 55) ? ffba_pkg::OP_ALLOC : ffba_pkg::OP_RELEASE;
			size = 17'($urandom_range(0, 512));
			off = 16'($urandom);
			pick = $urandom_range(99);
			if (op == ffba_pkg::OP_ALLOC) begin
				if (pick >= 95)
					size = 17'($urandom);
				else if (pick >= 90)
					size = 17'($urandom_range(0, 65536));
				else if (pick >= 80)
					size = 17'($urandom_range(0, 8192));
			end else begin
				if (pick < 75)
					off = 16'(int'(blk_start[$urandom_range(0, blk_count - 1)]) + HDR);
				else if (pick < 82)
					off = 16'd0;
			end
			send(op, size, off);
		end
		@(negedge clk);
		in_valid = 1'b0;

		wait (pending_grants.size() == 0);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
